// ===== hw/rtl/csl_pkg.sv =====
// shared types, codes and field widths for the cursor sequence list
`timescale 1ns / 1ps
`default_nettype none

package csl_pkg;

	localparam int unsigned VAL_W = 32;
	localparam int unsigned CMD_W = 3;
	localparam int unsigned CNT_W = 6;
	localparam int unsigned ERR_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_START   = 3'd0,
		CMD_ADVANCE = 3'd1,
		CMD_INSERT  = 3'd2,
		CMD_ATTACH  = 3'd3,
		CMD_REMOVE  = 3'd4
	} cmd_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic step;
		logic place;
		logic drop;
		logic read;
		logic publish;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic is_put;
		logic is_remove;
		logic full;
		logic has_item;
		logic shift;
		logic last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csl_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface csl_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [31:0] entry_value;

	modport source (output valid, output command, output entry_value, input ready);
	modport sink (input valid, input command, input entry_value, output ready);
endinterface

interface csl_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] current_value;
	logic        cursor_valid;
	logic [5:0]  item_count;
	logic [1:0]  error_code;

	modport source (output valid, output current_value, output cursor_valid,
		output item_count, output error_code, input ready);
	modport sink (input valid, input current_value, input cursor_valid,
		input item_count, input error_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/csl_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module csl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/csl_ctrl.sv =====
// sequencing state machine for the cursor sequence list
`timescale 1ns / 1ps
`default_nettype none

module csl_ctrl import csl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_ready,
	input  wire stat_t stat,
	output ctrl_t      ctrl
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EXEC  = 8'b0000_0010,
		S_SHIFT = 8'b0000_0100,
		S_DRAIN = 8'b0000_1000,
		S_PLACE = 8'b0001_0000,
		S_DROP  = 8'b0010_0000,
		S_READ  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		ctrl      = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctrl.load = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				ctrl.exec = 1'b1;
				priority if (stat.is_put && !stat.full) begin
					state_d = stat.shift ? S_SHIFT : S_PLACE;
				end else if (stat.is_remove && stat.has_item) begin
					state_d = stat.shift ? S_SHIFT : S_DROP;
				end else begin
					state_d = S_READ;
				end
			end
			S_SHIFT: begin
				ctrl.step = 1'b1;
				if (stat.last) begin
					state_d = S_DRAIN;
				end
			end
			// last moved entry lands here
			S_DRAIN: begin
				state_d = stat.is_remove ? S_DROP : S_PLACE;
			end
			S_PLACE: begin
				ctrl.place = 1'b1;
				state_d    = S_READ;
			end
			S_DROP: begin
				ctrl.drop = 1'b1;
				state_d   = S_READ;
			end
			S_READ: begin
				ctrl.read = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					ctrl.publish = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/csl_dp.sv =====
// list storage, cursor, count and result register
`timescale 1ns / 1ps
`default_nettype none

module csl_dp import csl_pkg::*; #(
	parameter int unsigned CAPACITY = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CMD_W-1:0] command,
	input  wire logic [VAL_W-1:0] entry_value,
	input  wire ctrl_t            ctrl,
	output stat_t                 stat,
	csl_rsp_if.source             rsp
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = $clog2(CAPACITY);

	logic [CW-1:0]    cursor_q;
	logic [CW-1:0]    count_q;
	logic             pend_s1;
	logic             out_valid_q;

	logic [CMD_W-1:0] cmd_q;
	logic [VAL_W-1:0] val_q;
	err_t             err_q;
	logic [CW-1:0]    pos_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    end_q;
	logic [AW-1:0]    pend_idx_s1;

	logic [VAL_W-1:0] value_q;
	logic             cur_valid_q;
	logic [CNT_W-1:0] item_count_q;
	logic [ERR_W-1:0] err_out_q;

	logic             has_item;
	logic             full;
	logic             is_put;
	logic             is_remove;
	logic [CW-1:0]    cursor_inc;
	logic [CW-1:0]    pos_sel;
	logic             shift;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;

	assign has_item   = cursor_q < count_q;
	assign full       = count_q >= CW'(CAPACITY);
	assign is_put     = (cmd_q == CMD_INSERT) || (cmd_q == CMD_ATTACH);
	assign is_remove  = cmd_q == CMD_REMOVE;
	assign cursor_inc = cursor_q + CW'(1);

	// insert goes before the cursor, attach after it; no current item means front or end
	always_comb begin
		if (cmd_q == CMD_ATTACH) begin
			pos_sel = has_item ? cursor_inc : count_q;
		end else begin
			pos_sel = has_item ? cursor_q : '0;
		end
	end

	assign shift = is_remove ? (cursor_inc < count_q) : (count_q != pos_sel);

	assign stat.is_put    = is_put;
	assign stat.is_remove = is_remove;
	assign stat.full      = full;
	assign stat.has_item  = has_item;
	assign stat.shift     = shift;
	assign stat.last      = idx_q == end_q;
	assign stat.out_free  = !out_valid_q || rsp.ready;

	// one entry moves per cycle: read here, written a place on the next cycle
	assign wr_en   = ctrl.place || pend_s1;
	assign wr_addr = ctrl.place ? pos_q[AW-1:0]
		: (is_remove ? pend_idx_s1 - AW'(1) : pend_idx_s1 + AW'(1));
	assign wr_data = ctrl.place ? val_q : rd_data;
	assign rd_en   = ctrl.step || (ctrl.read && has_item);
	assign rd_addr = ctrl.step ? idx_q : cursor_q[AW-1:0];

	csl_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= ctrl.step;
			if (ctrl.exec) begin
				if (cmd_q == CMD_START) begin
					cursor_q <= '0;
				end else if ((cmd_q == CMD_ADVANCE) && has_item) begin
					cursor_q <= cursor_inc;
				end
			end
			if (ctrl.place) begin
				count_q  <= count_q + CW'(1);
				cursor_q <= pos_q;
			end
			if (ctrl.drop) begin
				count_q <= count_q - CW'(1);
			end
			if (ctrl.publish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= command;
			val_q <= entry_value;
		end
		if (ctrl.exec) begin
			priority if (is_put && full) begin
				err_q <= ERR_FULL;
			end else if (is_remove && !has_item) begin
				err_q <= ERR_EMPTY;
			end else begin
				err_q <= ERR_OK;
			end
			pos_q <= pos_sel;
			if (is_remove) begin
				idx_q <= cursor_inc[AW-1:0];
				end_q <= AW'(count_q - CW'(1));
			end else begin
				idx_q <= AW'(count_q - CW'(1));
				end_q <= pos_sel[AW-1:0];
			end
		end
		if (ctrl.step) begin
			idx_q       <= is_remove ? idx_q + AW'(1) : idx_q - AW'(1);
			pend_idx_s1 <= idx_q;
		end
		if (ctrl.publish) begin
			value_q      <= has_item ? rd_data : '0;
			cur_valid_q  <= has_item;
			item_count_q <= CNT_W'(count_q);
			err_out_q    <= err_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.current_value = value_q;
	assign rsp.cursor_valid  = cur_valid_q;
	assign rsp.item_count    = item_count_q;
	assign rsp.error_code    = err_out_q;

`ifndef NO_ASSERTIONS
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_q <= count_q) && (count_q <= CW'(CAPACITY)))
		else $error("cursor or count out of range");

	a_place_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.place |-> !pend_s1)
		else $error("placement collides with a pending shift write");

	a_place_counts: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.place |=> (count_q == $past(count_q) + CW'(1)))
		else $error("placement did not grow the list by one");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.publish |-> (!out_valid_q || rsp.ready))
		else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cursor_sequence_list_unit.sv =====
// top level of the cursor sequence list
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   command, entry_value
//  rsp      out  valid/ready   current_value, cursor_valid, item_count, error_code
//
// one request at a time; start, advance and rejected requests go through exec, read and out
// insert and attach: exec, shift and drain if entries move up, then place, read and out;
// remove: entries move down, drop for place; one entry moves per cycle through the ram port
// reset clears cursor, count and handshake state; ram contents need no clearing
// a stalled result holds in the output register; the next request is still taken and worked,
// then waits in the last state until the register frees
`timescale 1ns / 1ps
`default_nettype none

module cursor_sequence_list_unit import csl_pkg::*; #(
	parameter int unsigned CAPACITY = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	csl_req_if.sink   req,
	csl_rsp_if.source rsp
);

	ctrl_t ctrl;
	stat_t stat;
	logic  req_ready;

	assign req.ready = req_ready;

	csl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	csl_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (req.command),
		.entry_value (req.entry_value),
		.ctrl        (ctrl),
		.stat        (stat),
		.rsp         (rsp)
	);

endmodule

`default_nettype wire
